// File: hdl/clp_pkg.sv
// ----------------------------------------------------------------------------
// Contiguous layer partitioner package
// Word codes, status codes, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
package clp_pkg;

	// Fixed widths of the word fields.
	localparam int FUNC_W   = 2;
	localparam int IDX_W    = 6;
	localparam int SLOT_W   = 3;
	localparam int STATUS_W = 2;

	// Parameter defaults.
	localparam int DEF_MAX_LAYERS = 64;
	localparam int DEF_MAX_SLOTS  = 8;
	localparam int DEF_BYTE_BITS  = 48;

	// Input word function codes.
	localparam logic [FUNC_W-1:0] FUNC_LAYER = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SLOT  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SOLVE = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_FIT   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NO_SLOTS = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

endpackage

// File: hdl/clp_muldiv.sv
// ----------------------------------------------------------------------------
// Multiply-divide unit
// Computes floor(a*b/d) by shift-add multiplication, then restoring division,
// one bit per cycle. The quotient must fit in AW bits (b <= d).
// ----------------------------------------------------------------------------
module clp_muldiv #(
	parameter int AW = 62,
	parameter int BW = 48,
	parameter int DW = 62
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	input  logic [DW-1:0] d,
	output logic          busy,
	output logic [AW-1:0] q
);

	localparam int PW = AW + BW;
	localparam int CW = $clog2(PW + 1);

	typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

	md_state_t     state_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [DW-1:0] d_q;
	logic [PW-1:0] prod_q;
	logic [PW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW:0]   rem_n;

	// Next partial remainder with the next dividend bit shifted in.
	assign rem_n = {rem_q[DW-1:0], prod_q[PW-1]};

	// Sequencer: multiply phase, then divide phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				MD_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						d_q     <= d;
						prod_q  <= '0;
						cnt_q   <= CW'(BW);
						state_q <= MD_MUL;
					end
				end
				MD_MUL: begin
					prod_q <= {prod_q[PW-2:0], 1'b0} + (b_q[BW-1] ? PW'(a_q) : '0);
					b_q    <= {b_q[BW-2:0], 1'b0};
					if (cnt_q == CW'(1)) begin
						cnt_q   <= CW'(PW);
						rem_q   <= '0;
						quo_q   <= '0;
						state_q <= MD_DIV;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				MD_DIV: begin
					prod_q <= {prod_q[PW-2:0], 1'b0};
					if (rem_n >= {1'b0, d_q}) begin
						rem_q <= rem_n - {1'b0, d_q};
						quo_q <= {quo_q[PW-2:0], 1'b1};
					end else begin
						rem_q <= rem_n;
						quo_q <= {quo_q[PW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= MD_IDLE;
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	assign busy = (state_q != MD_IDLE);
	assign q    = quo_q[AW-1:0];

endmodule

// File: hdl/contiguous_layer_partitioner.sv
// ----------------------------------------------------------------------------
// Contiguous layer partitioner
// Splits loaded layers into contiguous blocks, one per slot, and reports the
// slot of every layer.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one word per accepted cycle. A layer-size or
// slot-capacity load word is stored in the cycle it is accepted and gives no
// result, so loads stream at one word per cycle while no solve runs. A solve
// word runs the sequencer: a greedy fill, the capacity and layer sums, then for
// each slot but the last a target from the multiply-divide unit and a walk that
// moves the cut earlier, each move proven by another greedy fill over the
// remaining layers. A greedy fill reads and tests each layer in turn and
// closes a slot when the next layer does not fit or none is left.
// in_stall stays high for the whole solve and until its last result word has
// been placed in the output register. The solve then gives one result word per
// layer, or one status word, with last set on the final one. The output register
// holds its word while out_stall is high; the sequencer waits on it. Reset
// clears the load counts, the overflow flag and the sequencer; stored sizes
// and capacities are not cleared and only loaded entries are ever read.
// ----------------------------------------------------------------------------
module contiguous_layer_partitioner #(
	parameter int MAX_LAYERS = clp_pkg::DEF_MAX_LAYERS,
	parameter int MAX_SLOTS  = clp_pkg::DEF_MAX_SLOTS,
	parameter int BYTE_BITS  = clp_pkg::DEF_BYTE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [clp_pkg::FUNC_W-1:0]   func,
	input  logic [BYTE_BITS-1:0]         value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [clp_pkg::IDX_W-1:0]    layer_index,
	output logic [clp_pkg::SLOT_W-1:0]   slot,
	output logic                         entry_valid,
	output logic [clp_pkg::STATUS_W-1:0] status,
	output logic                         last
);

	localparam int LCW = $clog2(MAX_LAYERS + 1);
	localparam int SCW = $clog2(MAX_SLOTS + 1);
	localparam int LA  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int SA  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SW  = BYTE_BITS + LCW + SCW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_G_RD, ST_G_CMP, ST_SUMCAP, ST_SUMLAY_RD, ST_SUMLAY_ADD,
		ST_ADJ_START, ST_ADJ_BLK_RD, ST_ADJ_BLK_ADD, ST_ADJ_WAIT, ST_ADJ_TEST,
		ST_ADJ_CMP, ST_EMIT, ST_ERR
	} state_t;

	state_t                       state_q;
	logic [BYTE_BITS-1:0]         lay_mem [MAX_LAYERS];
	logic [BYTE_BITS-1:0]         lsz_q;
	logic [BYTE_BITS-1:0]         cap_q   [MAX_SLOTS];
	logic [LCW-1:0]               cut_q   [MAX_SLOTS];
	logic [LCW-1:0]               probe_q [MAX_SLOTS];
	logic [LCW-1:0]               layers_q;
	logic [SCW-1:0]               slots_q;
	logic                         ovf_q;
	logic [LCW-1:0]               g_l_q;
	logic [SCW-1:0]               g_s_q;
	logic [SW-1:0]                g_blk_q;
	logic                         g_probe_q;
	logic [SW-1:0]                tcap_q;
	logic [SW-1:0]                tlay_q;
	logic [SCW-1:0]               a_s_q;
	logic [LCW-1:0]               a_i_q;
	logic [LCW-1:0]               a_beg_q;
	logic [LCW-1:0]               a_cand_q;
	logic [SW-1:0]                a_blk_q;
	logic [SW-1:0]                a_red_q;
	logic [SW-1:0]                tgt_q;
	logic [LCW-1:0]               e_i_q;
	logic [SCW-1:0]               e_s_q;
	logic [clp_pkg::STATUS_W-1:0] err_q;
	logic                         out_valid_q;
	logic [clp_pkg::IDX_W-1:0]    layer_index_q;
	logic [clp_pkg::SLOT_W-1:0]   slot_q;
	logic                         entry_valid_q;
	logic [clp_pkg::STATUS_W-1:0] status_q;
	logic                         last_q;

	logic                         in_acc;
	logic                         out_free;
	logic                         out_load;
	logic                         lay_we;
	logic [LCW-1:0]               rd_addr;
	logic [LCW-1:0]               cut_cur;
	logic [LCW-1:0]               cut_prev;
	logic [LCW-1:0]               cut_emit;
	logic [BYTE_BITS-1:0]         cap_g;
	logic [SW-1:0]                reduced;
	logic [SW-1:0]                before_d;
	logic [SW-1:0]                after_d;
	logic                         md_start;
	logic                         md_busy;
	logic [SW-1:0]                md_q;

	// Handshake terms.
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign lay_we   = in_acc && (func == clp_pkg::FUNC_LAYER) &&
	                  (layers_q < LCW'(MAX_LAYERS));

	// A new result word enters the output register this cycle.
	assign out_load = out_free &&
	                  (((state_q == ST_EMIT) && (layers_q != '0) && (e_i_q < cut_emit)) ||
	                   (state_q == ST_ERR));

	// Frequently used table reads.
	assign cut_cur  = cut_q[a_s_q[SA-1:0]];
	assign cut_prev = (a_s_q == '0) ? '0 : cut_q[SA'(a_s_q - 1'b1)];
	assign cut_emit = cut_q[e_s_q[SA-1:0]];
	assign cap_g    = cap_q[g_s_q[SA-1:0]];

	// Distance terms of one cut move.
	assign reduced  = a_blk_q - SW'(lsz_q);
	assign before_d = a_blk_q - tgt_q;
	assign after_d  = (reduced >= tgt_q) ? (reduced - tgt_q) : (tgt_q - reduced);

	// Layer memory read address.
	always_comb begin
		case (state_q)
			ST_SUMLAY_RD:  rd_addr = a_i_q;
			ST_ADJ_BLK_RD: rd_addr = a_i_q;
			ST_ADJ_TEST:   rd_addr = cut_cur - 1'b1;
			default:       rd_addr = g_l_q;
		endcase
	end

	// Layer size memory with registered read.
	always_ff @(posedge clk) begin
		if (lay_we) begin
			lay_mem[layers_q[LA-1:0]] <= value;
		end
		lsz_q <= lay_mem[rd_addr[LA-1:0]];
	end

	assign md_start = (state_q == ST_ADJ_START) && (tcap_q != '0) &&
	                  (({1'b0, a_s_q} + 1'b1) < {1'b0, slots_q});

	// Target = floor(total_layer_size * cap / total_cap).
	clp_muldiv #(
		.AW (SW),
		.BW (BYTE_BITS),
		.DW (SW)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.a      (tlay_q),
		.b      (cap_q[a_s_q[SA-1:0]]),
		.d      (tcap_q),
		.busy   (md_busy),
		.q      (md_q)
	);

	// Sequencer, load counters and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			layers_q    <= '0;
			slots_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			g_probe_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (func == clp_pkg::FUNC_LAYER) begin
							if (lay_we) layers_q <= layers_q + 1'b1;
							else ovf_q <= 1'b1;
						end else if (func == clp_pkg::FUNC_SLOT) begin
							if (slots_q < SCW'(MAX_SLOTS)) begin
								cap_q[slots_q[SA-1:0]] <= value;
								slots_q <= slots_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end else if (func == clp_pkg::FUNC_SOLVE) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (ovf_q) begin
						err_q   <= clp_pkg::STAT_OVERFLOW;
						state_q <= ST_ERR;
					end else if (slots_q == '0) begin
						err_q   <= clp_pkg::STAT_NO_SLOTS;
						state_q <= ST_ERR;
					end else begin
						g_l_q     <= '0;
						g_s_q     <= '0;
						g_blk_q   <= '0;
						g_probe_q <= 1'b0;
						state_q   <= ST_G_RD;
					end
				end
				// Greedy fill: one slot closes or one layer is read per pass.
				ST_G_RD: begin
					if (g_s_q == slots_q) begin
						if (!g_probe_q) begin
							if (g_l_q != layers_q) begin
								err_q   <= clp_pkg::STAT_NO_FIT;
								state_q <= ST_ERR;
							end else begin
								tcap_q  <= '0;
								a_s_q   <= '0;
								state_q <= ST_SUMCAP;
							end
						end else if (g_l_q == layers_q) begin
							// The probe fill succeeded: commit the moved cut.
							for (int k = 0; k < MAX_SLOTS; k++) begin
								if (SCW'(k) > a_s_q) cut_q[k] <= probe_q[k];
							end
							cut_q[a_s_q[SA-1:0]] <= a_cand_q;
							a_blk_q <= a_red_q;
							state_q <= ST_ADJ_TEST;
						end else begin
							a_s_q   <= a_s_q + 1'b1;
							state_q <= ST_ADJ_START;
						end
					end else if (g_l_q < layers_q) begin
						state_q <= ST_G_CMP;
					end else begin
						if (g_probe_q) probe_q[g_s_q[SA-1:0]] <= g_l_q;
						else cut_q[g_s_q[SA-1:0]] <= g_l_q;
						g_s_q   <= g_s_q + 1'b1;
						g_blk_q <= '0;
					end
				end
				ST_G_CMP: begin
					if (SW'(lsz_q) <= SW'(cap_g) - g_blk_q) begin
						g_blk_q <= g_blk_q + SW'(lsz_q);
						g_l_q   <= g_l_q + 1'b1;
					end else begin
						if (g_probe_q) probe_q[g_s_q[SA-1:0]] <= g_l_q;
						else cut_q[g_s_q[SA-1:0]] <= g_l_q;
						g_s_q   <= g_s_q + 1'b1;
						g_blk_q <= '0;
					end
					state_q <= ST_G_RD;
				end
				// Total capacity, one slot per cycle.
				ST_SUMCAP: begin
					if (a_s_q < slots_q) begin
						tcap_q <= tcap_q + SW'(cap_q[a_s_q[SA-1:0]]);
						a_s_q  <= a_s_q + 1'b1;
					end else begin
						a_s_q   <= '0;
						a_i_q   <= '0;
						tlay_q  <= '0;
						state_q <= ST_SUMLAY_RD;
					end
				end
				// Total of layer sizes, each layer read and then added.
				ST_SUMLAY_RD: begin
					if (a_i_q < layers_q) state_q <= ST_SUMLAY_ADD;
					else state_q <= ST_ADJ_START;
				end
				ST_SUMLAY_ADD: begin
					tlay_q  <= tlay_q + SW'(lsz_q);
					a_i_q   <= a_i_q + 1'b1;
					state_q <= ST_SUMLAY_RD;
				end
				// Adjustment of one slot's cut.
				ST_ADJ_START: begin
					if (md_start) begin
						a_beg_q <= cut_prev;
						a_i_q   <= cut_prev;
						a_blk_q <= '0;
						state_q <= ST_ADJ_BLK_RD;
					end else begin
						e_i_q   <= '0;
						e_s_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_ADJ_BLK_RD: begin
					if (a_i_q < cut_cur) state_q <= ST_ADJ_BLK_ADD;
					else state_q <= ST_ADJ_WAIT;
				end
				ST_ADJ_BLK_ADD: begin
					a_blk_q <= a_blk_q + SW'(lsz_q);
					a_i_q   <= a_i_q + 1'b1;
					state_q <= ST_ADJ_BLK_RD;
				end
				ST_ADJ_WAIT: begin
					if (!md_busy) begin
						tgt_q   <= md_q;
						state_q <= ST_ADJ_TEST;
					end
				end
				ST_ADJ_TEST: begin
					if ((cut_cur > a_beg_q) && (a_blk_q > tgt_q)) begin
						a_cand_q <= cut_cur - 1'b1;
						state_q  <= ST_ADJ_CMP;
					end else begin
						a_s_q   <= a_s_q + 1'b1;
						state_q <= ST_ADJ_START;
					end
				end
				ST_ADJ_CMP: begin
					if (after_d >= before_d) begin
						a_s_q   <= a_s_q + 1'b1;
						state_q <= ST_ADJ_START;
					end else begin
						a_red_q   <= reduced;
						g_l_q     <= a_cand_q;
						g_s_q     <= a_s_q + 1'b1;
						g_blk_q   <= '0;
						g_probe_q <= 1'b1;
						state_q   <= ST_G_RD;
					end
				end
				// One result word per layer, or a status word when no layers are loaded.
				ST_EMIT: begin
					if (layers_q == '0) begin
						err_q   <= clp_pkg::STAT_OK;
						state_q <= ST_ERR;
					end else if (e_i_q >= cut_emit) begin
						e_s_q <= e_s_q + 1'b1;
					end else if (out_free) begin
						layer_index_q <= clp_pkg::IDX_W'(e_i_q);
						slot_q        <= clp_pkg::SLOT_W'(e_s_q);
						entry_valid_q <= 1'b1;
						status_q      <= clp_pkg::STAT_OK;
						last_q        <= (e_i_q + 1'b1 == layers_q);
						e_i_q         <= e_i_q + 1'b1;
						if (e_i_q + 1'b1 == layers_q) begin
							layers_q <= '0;
							slots_q  <= '0;
							ovf_q    <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end
				end
				// Single status word.
				ST_ERR: begin
					if (out_free) begin
						layer_index_q <= '0;
						slot_q        <= '0;
						entry_valid_q <= 1'b0;
						status_q      <= err_q;
						last_q        <= 1'b1;
						layers_q      <= '0;
						slots_q       <= '0;
						ovf_q         <= 1'b0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign layer_index = layer_index_q;
	assign slot        = slot_q;
	assign entry_valid = entry_valid_q;
	assign status      = status_q;
	assign last        = last_q;

	// Load counts never pass their store depths.
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(layers_q <= LCW'(MAX_LAYERS)) && (slots_q <= SCW'(MAX_SLOTS)))
		else $error("load count beyond store depth");

	// A layer load into a full store raises the overflow flag.
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (func == clp_pkg::FUNC_LAYER) && (layers_q == LCW'(MAX_LAYERS)))
		|=> ovf_q)
		else $error("excess layer load not flagged");

	// The emit walk never runs past the loaded slots.
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && (layers_q != '0) |-> (e_s_q < slots_q))
		else $error("emit slot index past loaded slots");

	// The probe fill always starts after the slot being adjusted.
	a_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_G_RD) && g_probe_q |-> (g_s_q > a_s_q))
		else $error("probe fill overlaps adjusted slot");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Contiguous layer partitioner testbench
// Streams layer-size and slot-capacity load words and solve words into the
// partitioner, predicts every result word with its own planner, and checks
// the results in order under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;

	localparam int NL  = clp_pkg::DEF_MAX_LAYERS;
	localparam int NS  = clp_pkg::DEF_MAX_SLOTS;
	localparam int BW  = clp_pkg::DEF_BYTE_BITS;
	localparam int FW  = clp_pkg::FUNC_W;
	localparam int IW  = clp_pkg::IDX_W;
	localparam int SLW = clp_pkg::SLOT_W;
	localparam int STW = clp_pkg::STATUS_W;
	localparam logic [FW-1:0] FUNC_NONE = 2'd3;
	localparam logic [BW-1:0] ALL_ONES = {BW{1'b1}};

	typedef struct packed {
		logic [IW-1:0]  layer_index;
		logic [SLW-1:0] slot;
		logic           entry_valid;
		logic [STW-1:0] status;
		logic           last;
	} result_t;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	logic [FW-1:0]  func;
	logic [BW-1:0]  value;
	logic           out_valid;
	logic           out_stall;
	logic [IW-1:0]  layer_index;
	logic [SLW-1:0] slot;
	logic           entry_valid;
	logic [STW-1:0] status;
	logic           last;

	// Planner state, mirroring what the block has loaded.
	longint unsigned sizes[NL];
	longint unsigned caps[NS];
	int              cuts[NS];
	int              trial[NS];
	int              n_layers;
	int              n_slots;
	bit              overflowed;

	result_t expected_words[$];
	int      errors;
	int      words_sent;
	int      send_idle_pct;
	int      stall_pct;
	int      hold_cycles;

	contiguous_layer_partitioner dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.layer_index(layer_index), .slot(slot), .entry_valid(entry_valid),
		.status(status), .last(last)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Greedy fill of layers from start_layer into slots from start_slot.
	function automatic bit greedy_fill(int start_layer, int start_slot);
		int layer;
		longint unsigned blk;
		layer = start_layer;
		for (int s = start_slot; s < n_slots; s++) begin
			blk = 0;
			while (layer < n_layers && sizes[layer] <= caps[s] - blk) begin
				blk += sizes[layer];
				layer++;
			end
			trial[s] = layer;
		end
		return layer == n_layers;
	endfunction

	// Works out the cut points; returns the status of the solve.
	function automatic logic [STW-1:0] plan_cuts();
		longint unsigned tcap, tlay, tgt, blk, red, gap_now, gap_next;
		int b, cand;
		if (overflowed)
			return clp_pkg::STAT_OVERFLOW;
		if (n_slots == 0)
			return clp_pkg::STAT_NO_SLOTS;
		if (!greedy_fill(0, 0))
			return clp_pkg::STAT_NO_FIT;
		for (int s = 0; s < n_slots; s++)
			cuts[s] = trial[s];
		tcap = 0;
		tlay = 0;
		for (int s = 0; s < n_slots; s++)
			tcap += caps[s];
		for (int i = 0; i < n_layers; i++)
			tlay += sizes[i];
		// Pull each cut earlier while the block nears its fair share.
		if (tcap != 0) begin
			for (int s = 0; s + 1 < n_slots; s++) begin
				b = (s == 0) ? 0 : cuts[s-1];
				tgt = 64'((128'(tlay) * 128'(caps[s])) / 128'(tcap));
				blk = 0;
				for (int i = b; i < cuts[s]; i++)
					blk += sizes[i];
				while (cuts[s] > b && blk > tgt) begin
					cand = cuts[s] - 1;
					red = blk - sizes[cand];
					gap_now = blk - tgt;
					gap_next = (red >= tgt) ? red - tgt : tgt - red;
					if (gap_next >= gap_now)
						break;
					if (!greedy_fill(cand, s + 1))
						break;
					cuts[s] = cand;
					for (int k = s + 1; k < n_slots; k++)
						cuts[k] = trial[k];
					blk = red;
				end
			end
		end
		b = 0;
		for (int s = 0; s < n_slots; s++) begin
			blk = 0;
			for (int i = b; i < cuts[s] && i < n_layers; i++)
				blk += sizes[i];
			if (blk > caps[s])
				return clp_pkg::STAT_NO_FIT;
			b = cuts[s];
		end
		if (b != n_layers)
			return clp_pkg::STAT_NO_FIT;
		return clp_pkg::STAT_OK;
	endfunction

	// Updates the planner for one accepted word and queues its results.
	task automatic predict_word(input logic [FW-1:0] f, input logic [BW-1:0] v);
		logic [STW-1:0] st;
		int b;
		result_t r;
		if (f == clp_pkg::FUNC_LAYER) begin
			if (n_layers < NL) sizes[n_layers++] = v;
			else overflowed = 1;
		end else if (f == clp_pkg::FUNC_SLOT) begin
			if (n_slots < NS) caps[n_slots++] = v;
			else overflowed = 1;
		end else if (f == clp_pkg::FUNC_SOLVE) begin
			st = plan_cuts();
			if (st != clp_pkg::STAT_OK || n_layers == 0) begin
				r = '{layer_index: '0, slot: '0, entry_valid: 1'b0, status: st, last: 1'b1};
				expected_words = {expected_words, r};
			end else begin
				b = 0;
				for (int s = 0; s < n_slots; s++) begin
					for (int i = b; i < cuts[s] && i < n_layers; i++) begin
						r.layer_index = IW'(i);
						r.slot = SLW'(s);
						r.entry_valid = 1'b1;
						r.status = clp_pkg::STAT_OK;
						r.last = (i + 1 == n_layers);
						expected_words = {expected_words, r};
					end
					b = cuts[s];
				end
			end
			n_layers = 0;
			n_slots = 0;
			overflowed = 0;
		end
	endtask

	// Offers one input word, with random idle cycles ahead of it.
	task automatic send_word(input logic [FW-1:0] f, input logic [BW-1:0] v);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		value = v;
		do @(posedge clk); while (in_stall);
		predict_word(f, v);
		words_sent++;
	endtask

	// Drops valid and waits until every expected word has come back.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Receiver stall pattern, with an optional long hold-off.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall = 1'b1;
			repeat (hold_cycles) @(negedge clk);
			hold_cycles = 0;
		end
		out_stall = ($urandom_range(0, 99) < stall_pct);
	end

	// Compares every accepted result word with the oldest expectation.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{layer_index, slot, entry_valid, status, last};
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word idx=%0d slot=%0d ev=%0b st=%0d last=%0b",
					$time, layer_index, slot, entry_valid, status, last);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected idx=%0d slot=%0d ev=%0b st=%0d last=%0b",
						$time, want.layer_index, want.slot, want.entry_valid,
						want.status, want.last);
					$display("%0t:          actual   idx=%0d slot=%0d ev=%0b st=%0d last=%0b",
						$time, got.layer_index, got.slot, got.entry_valid, got.status,
						got.last);
					errors++;
				end
			end
		end
	end

	function automatic logic [BW-1:0] rand48();
		return BW'({$urandom, $urandom});
	endfunction

	// Extremes, zero capacity, the basic split and an ignored word.
	task automatic test_directed_fits();
		send_word(clp_pkg::FUNC_LAYER, ALL_ONES);
		send_word(clp_pkg::FUNC_LAYER, '0);
		send_word(clp_pkg::FUNC_SLOT, ALL_ONES);
		send_word(clp_pkg::FUNC_SLOT, ALL_ONES);
		send_word(clp_pkg::FUNC_SOLVE, ALL_ONES);
		for (int i = 0; i < 6; i++)
			send_word(clp_pkg::FUNC_LAYER, 48'd3 + i);
		send_word(FUNC_NONE, ALL_ONES);
		send_word(clp_pkg::FUNC_SLOT, 48'd20);
		send_word(clp_pkg::FUNC_SLOT, 48'd10);
		send_word(clp_pkg::FUNC_SLOT, 48'd30);
		send_word(clp_pkg::FUNC_SOLVE, '0);
		// Zero total capacity keeps the greedy fill.
		send_word(clp_pkg::FUNC_LAYER, '0);
		send_word(clp_pkg::FUNC_SLOT, '0);
		send_word(clp_pkg::FUNC_SLOT, '0);
		send_word(clp_pkg::FUNC_SOLVE, '0);
		drain();
	endtask

	// Each error status and the solve with no layers.
	task automatic test_directed_errors();
		send_word(clp_pkg::FUNC_SOLVE, '0);
		send_word(clp_pkg::FUNC_LAYER, 48'd5);
		send_word(clp_pkg::FUNC_SOLVE, '0);
		send_word(clp_pkg::FUNC_SLOT, 48'd7);
		send_word(clp_pkg::FUNC_SOLVE, '0);
		send_word(clp_pkg::FUNC_LAYER, 48'd9);
		send_word(clp_pkg::FUNC_SLOT, 48'd8);
		send_word(clp_pkg::FUNC_SOLVE, '0);
		for (int i = 0; i < NS + 1; i++)
			send_word(clp_pkg::FUNC_SLOT, 48'd100);
		send_word(clp_pkg::FUNC_LAYER, 48'd1);
		send_word(clp_pkg::FUNC_SOLVE, '0);
		drain();
		// A full layer store, then one load too many.
		for (int i = 0; i < NL + 1; i++)
			send_word(clp_pkg::FUNC_LAYER, 48'd1);
		send_word(clp_pkg::FUNC_SLOT, 48'd1000);
		send_word(clp_pkg::FUNC_SOLVE, '0);
		for (int i = 0; i < NL; i++)
			send_word(clp_pkg::FUNC_LAYER, 48'(i + 1));
		for (int i = 0; i < NS; i++)
			send_word(clp_pkg::FUNC_SLOT, 48'd400);
		send_word(clp_pkg::FUNC_SOLVE, '0);
		drain();
	endtask

	// One job: well-formed with random content, broken or plain noise.
	task automatic random_job();
		int mode, nl, ns, li, si;
		logic [BW-1:0] mask, maxsz, sz;
		longint unsigned sum, c;
		logic [BW-1:0] job_sizes[NL];
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			repeat ($urandom_range(1, 8))
				send_word(FW'($urandom_range(0, 3)), rand48());
			return;
		end
		nl = ($urandom_range(0, 7) == 0) ? $urandom_range(1, NL) : $urandom_range(1, 10);
		ns = $urandom_range(1, NS);
		if (mode == 1) begin
			if ($urandom_range(0, 1)) ns = NS + 1;
			else nl = NL + 1;
		end
		case ($urandom_range(0, 2))
			0: mask = 48'hF;
			1: mask = 48'hFFFF;
			default: mask = ALL_ONES;
		endcase
		sum = 0;
		maxsz = 0;
		for (int i = 0; i < nl && i < NL; i++) begin
			sz = rand48() & mask;
			job_sizes[i] = sz;
			sum += sz;
			if (sz > maxsz) maxsz = sz;
		end
		li = 0;
		si = 0;
		while (li < nl || si < ns) begin
			if (li < nl && (si >= ns || $urandom_range(0, 2) != 0)) begin
				send_word(clp_pkg::FUNC_LAYER, job_sizes[li % NL]);
				li++;
			end else begin
				// Mostly roomy slots, now and then a tight or a full-range one.
				case ($urandom_range(0, 5))
					0: c = rand48() & mask;
					1: c = rand48();
					default: c = longint'(maxsz) + sum / ns + (rand48() & mask);
				endcase
				if (c > longint'(ALL_ONES)) c = ALL_ONES;
				send_word(clp_pkg::FUNC_SLOT, BW'(c));
				si++;
			end
		end
		send_word(clp_pkg::FUNC_SOLVE, rand48());
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_p, input int words);
		int stop_at;
		send_idle_pct = idle_pct;
		stall_pct = stall_p;
		stop_at = words_sent + words;
		while (words_sent < stop_at)
			random_job();
		drain();
	endtask

	// The receiver holds off while the sender keeps offering words.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 400;
		for (int i = 0; i < 20; i++)
			send_word(clp_pkg::FUNC_LAYER, 48'(i + 2));
		for (int i = 0; i < 4; i++)
			send_word(clp_pkg::FUNC_SLOT, 48'd80);
		send_word(clp_pkg::FUNC_SOLVE, '0);
		for (int i = 0; i < 5; i++)
			send_word(clp_pkg::FUNC_LAYER, 48'(i));
		send_word(clp_pkg::FUNC_SLOT, 48'd50);
		send_word(clp_pkg::FUNC_SOLVE, '0);
		drain();
	endtask

	initial begin
		errors = 0;
		words_sent = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		n_layers = 0;
		n_slots = 0;
		overflowed = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = clp_pkg::FUNC_LAYER;
		value = '0;
		out_stall = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_fits();
		test_directed_errors();
		test_backpressure();
		test_random_phase(0, 0, 65);
		test_random_phase(68, 0, 65);
		test_random_phase(0, 68, 65);
		test_random_phase(22, 22, 65);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#400_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: contiguous_layer_partitioner.f
hdl/clp_pkg.sv
hdl/clp_muldiv.sv
hdl/contiguous_layer_partitioner.sv
verif/tb.sv
